// File: hdl/idalloc_pkg.sv
// shared types, constants and codes for the id allocator with reuse delay
// no dependencies; used by the interfaces and every module of the block
package idalloc_pkg;

    localparam int ID_BITS        = 10;
    localparam int COUNT_BITS     = ID_BITS + 1;
    localparam int POOL_DEPTH     = 1 << ID_BITS;
    localparam int HOLD_DEPTH     = 97;
    localparam int HOLD_POS_BITS  = $clog2(HOLD_DEPTH);
    localparam int HOLD_FILL_BITS = $clog2(HOLD_DEPTH + 1);
    localparam int SEED_BITS      = 32;
    localparam int CFG_DATA_BITS  = 32;

    // seed + held id + ring position + counter, padded to a whole number of radix-4 steps
    localparam int MIX_BITS      = 34;
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_CYCLES    = MIX_BITS / DIV_STEP_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_CYCLES);

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic CFG_START_ID  = 1'b0;
    localparam logic CFG_PICK_SEED = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [ID_BITS-1:0] id_value;
    } t_req;

    typedef struct packed {
        logic [ID_BITS-1:0] granted_id;
        logic               was_issued;
        logic [1:0]         status;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_start;
        logic pool_rd_last;
        logic pick_load;
        logic commit_alloc;
        logic commit_release;
        logic commit_simple;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] operation;
        logic       pool_empty;
        logic       in_range;
        logic       div_done;
    } t_stat;

endpackage

// File: hdl/idalloc_if.sv
// valid/ready channel interfaces for requests and responses
// depends on idalloc_pkg for the payload types
interface idalloc_req_if;
    logic               valid;
    logic               ready;
    idalloc_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface idalloc_rsp_if;
    logic               valid;
    logic               ready;
    idalloc_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/idalloc_divider.sv
// remainder unit: mix mod pool count, two quotient bits per cycle
// depends on idalloc_pkg
module idalloc_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [idalloc_pkg::MIX_BITS-1:0]    i_dividend,
    input  logic [idalloc_pkg::COUNT_BITS-1:0]  i_divisor,
    output logic                                o_done,
    output logic [idalloc_pkg::ID_BITS-1:0]     o_rem
);

    logic [idalloc_pkg::MIX_BITS-1:0]     r_dvd;
    logic [idalloc_pkg::COUNT_BITS-1:0]   r_dvs;
    logic [idalloc_pkg::ID_BITS-1:0]      r_rem;
    logic [idalloc_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic                                 r_busy;
    logic                                 r_done;
    logic [idalloc_pkg::ID_BITS-1:0]      n_rem;

    // restoring steps; remainder stays below the divisor, so it fits the id width
    always_comb begin
        logic [idalloc_pkg::COUNT_BITS-1:0] trial;
        logic [idalloc_pkg::ID_BITS-1:0]    rem;
        rem = r_rem;
        for (int k = 0; k < idalloc_pkg::DIV_STEP_BITS; k++) begin
            trial = {rem, r_dvd[idalloc_pkg::MIX_BITS-1-k]};
            if (trial >= r_dvs) begin
                rem = idalloc_pkg::ID_BITS'(trial - r_dvs);
            end else begin
                rem = trial[idalloc_pkg::ID_BITS-1:0];
            end
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == idalloc_pkg::DIV_CNT_BITS'(idalloc_pkg::DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << idalloc_pkg::DIV_STEP_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: hdl/idalloc_ctrl.sv
// sequencing state machine for the id allocator
// depends on idalloc_pkg; drives the datapath through t_cmd, watches t_stat
module idalloc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  idalloc_pkg::t_stat i_stat,
    output idalloc_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_DIV      = 3'd2;
    localparam logic [2:0] S_POOL_RD  = 3'd3;
    localparam logic [2:0] S_COMMIT_A = 3'd4;
    localparam logic [2:0] S_COMMIT_R = 3'd5;
    localparam logic [2:0] S_COMMIT_S = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;
    logic       w_commit;

    // result register is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.operation == idalloc_pkg::OP_ALLOC && !i_stat.pool_empty) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_stat.operation == idalloc_pkg::OP_RELEASE && i_stat.in_range) begin
                    n_state = S_COMMIT_R;
                end else begin
                    n_state = S_COMMIT_S;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_POOL_RD;
                end
            end
            S_POOL_RD: begin
                o_cmd.pool_rd_last = 1'b1;
                o_cmd.pick_load    = 1'b1;
                n_state            = S_COMMIT_A;
            end
            S_COMMIT_A: begin
                // keep the last entry on the read port while waiting
                o_cmd.pool_rd_last = 1'b1;
                o_cmd.commit_alloc = w_out_free;
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_COMMIT_R: begin
                o_cmd.commit_release = w_out_free;
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_COMMIT_S: begin
                o_cmd.commit_simple = w_out_free;
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_commit = o_cmd.commit_alloc || o_cmd.commit_release || o_cmd.commit_simple;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/idalloc_dpath.sv
// datapath: config registers, counter, hold ring, free pool, result register
// depends on idalloc_pkg and idalloc_divider
module idalloc_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [idalloc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  idalloc_pkg::t_req                     i_req,
    output idalloc_pkg::t_rsp                     o_rsp,
    input  idalloc_pkg::t_cmd                     i_cmd,
    output idalloc_pkg::t_stat                    o_stat
);

    localparam int IB = idalloc_pkg::ID_BITS;
    localparam int CB = idalloc_pkg::COUNT_BITS;
    localparam int PB = idalloc_pkg::HOLD_POS_BITS;
    localparam int FB = idalloc_pkg::HOLD_FILL_BITS;
    localparam int MB = idalloc_pkg::MIX_BITS;

    logic [IB-1:0]                     r_start_id;
    logic [idalloc_pkg::SEED_BITS-1:0] r_seed;
    logic [CB-1:0]                     r_next_fresh;
    logic [PB-1:0]                     r_hold_pos;
    logic [FB-1:0]                     r_hold_fill;
    logic [CB-1:0]                     r_pool_count;

    logic [1:0]    r_op;
    logic [IB-1:0] r_id;

    logic [IB-1:0] r_ring [idalloc_pkg::HOLD_DEPTH];
    logic [IB-1:0] r_ring_q;
    logic [IB-1:0] r_pool [idalloc_pkg::POOL_DEPTH];
    logic [IB-1:0] r_pool_q;
    logic [IB-1:0] r_pick_val;

    idalloc_pkg::t_rsp r_rsp;
    idalloc_pkg::t_rsp n_rsp;

    logic          w_in_range;
    logic          w_ring_full;
    logic          w_pool_full;
    logic [MB-1:0] w_mix;
    logic          w_div_done;
    logic [IB-1:0] w_pick;
    logic [IB-1:0] w_pool_last;
    logic [IB-1:0] w_pool_raddr;
    logic          w_pool_we;
    logic [IB-1:0] w_pool_waddr;
    logic [IB-1:0] w_pool_wdata;
    logic          w_restart;

    assign w_in_range  = ({1'b0, r_id} >= {1'b0, r_start_id}) && ({1'b0, r_id} < r_next_fresh);
    assign w_ring_full = (r_hold_fill >= FB'(idalloc_pkg::HOLD_DEPTH));
    assign w_pool_full = r_pool_count[IB];
    assign w_pool_last = IB'(r_pool_count - 1'b1);
    assign w_restart   = i_cfg_we && (i_cfg_idx == idalloc_pkg::CFG_START_ID);

    assign w_mix = MB'(r_seed) + MB'(r_ring_q) + MB'(r_hold_pos) + MB'(r_next_fresh);

    idalloc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mix),
        .i_divisor  (r_pool_count),
        .o_done     (w_div_done),
        .o_rem      (w_pick)
    );

    assign o_stat.operation  = r_op;
    assign o_stat.pool_empty = (r_pool_count == '0);
    assign o_stat.in_range   = w_in_range;
    assign o_stat.div_done   = w_div_done;

    // captured request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_req.operation;
            r_id <= i_req.id_value;
        end
    end

    // hold ring: read at the current position every cycle, written on a release
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_release) begin
            r_ring[r_hold_pos] <= r_id;
        end
        r_ring_q <= r_ring[r_hold_pos];
    end

    // free pool: one write and one registered read per cycle
    assign w_pool_raddr = i_cmd.pool_rd_last ? w_pool_last : w_pick;

    always_comb begin
        w_pool_we    = 1'b0;
        w_pool_waddr = w_pick;
        w_pool_wdata = r_pool_q;
        if (i_cmd.commit_alloc) begin
            // last entry fills the gap left by the picked one
            w_pool_we = 1'b1;
        end else if (i_cmd.commit_release && w_ring_full && !w_pool_full) begin
            w_pool_we    = 1'b1;
            w_pool_waddr = r_pool_count[IB-1:0];
            w_pool_wdata = r_ring_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pool_we) begin
            r_pool[w_pool_waddr] <= w_pool_wdata;
        end
        r_pool_q <= r_pool[w_pool_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick_load) begin
            r_pick_val <= r_pool_q;
        end
    end

    // result of the finishing transaction
    always_comb begin
        n_rsp = '0;
        if (i_cmd.commit_alloc) begin
            n_rsp.granted_id = r_pick_val;
        end else if (i_cmd.commit_release) begin
            if (w_ring_full && w_pool_full) begin
                n_rsp.status = idalloc_pkg::ST_OVERFLOW;
            end
        end else begin
            case (r_op)
                idalloc_pkg::OP_ALLOC: begin
                    if (r_next_fresh[IB]) begin
                        n_rsp.status = idalloc_pkg::ST_EXHAUSTED;
                    end else begin
                        n_rsp.granted_id = r_next_fresh[IB-1:0];
                    end
                end
                idalloc_pkg::OP_RELEASE: begin
                    n_rsp.status = idalloc_pkg::ST_RANGE;
                end
                idalloc_pkg::OP_QUERY: begin
                    n_rsp.was_issued = w_in_range;
                end
                default: begin
                    n_rsp = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_alloc || i_cmd.commit_release || i_cmd.commit_simple) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

    // configuration and bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_id   <= '0;
            r_seed       <= '0;
            r_next_fresh <= '0;
            r_hold_pos   <= '0;
            r_hold_fill  <= '0;
            r_pool_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                idalloc_pkg::CFG_START_ID: begin
                    r_start_id <= i_cfg_data[IB-1:0];
                end
                idalloc_pkg::CFG_PICK_SEED: begin
                    r_seed <= i_cfg_data[idalloc_pkg::SEED_BITS-1:0];
                end
                default: begin
                    r_seed <= r_seed;
                end
            endcase
            // new start id empties ring and pool and reloads the counter
            if (w_restart) begin
                r_next_fresh <= {1'b0, i_cfg_data[IB-1:0]};
                r_hold_pos   <= '0;
                r_hold_fill  <= '0;
                r_pool_count <= '0;
            end
        end else if (i_cmd.commit_alloc) begin
            r_pool_count <= r_pool_count - 1'b1;
        end else if (i_cmd.commit_release) begin
            if (w_ring_full && !w_pool_full) begin
                r_pool_count <= r_pool_count + 1'b1;
            end
            if (!w_ring_full) begin
                r_hold_fill <= r_hold_fill + 1'b1;
            end
            if (r_hold_pos == PB'(idalloc_pkg::HOLD_DEPTH - 1)) begin
                r_hold_pos <= '0;
            end else begin
                r_hold_pos <= r_hold_pos + 1'b1;
            end
        end else if (i_cmd.commit_simple) begin
            if (r_op == idalloc_pkg::OP_ALLOC && !r_next_fresh[IB]) begin
                r_next_fresh <= r_next_fresh + 1'b1;
            end
        end
    end

endmodule

// File: hdl/id_allocator_with_reuse_delay_top.sv
// top level of the id allocator with reuse delay
// depends on idalloc_pkg, idalloc_if, idalloc_ctrl, idalloc_dpath
//
// hands out unique 10-bit ids, one request transaction at a time. a request
// is taken only when the block is idle; the response sits in an output
// register, so the next request is taken while it waits. allocate from the
// free pool goes through capture, decode, the remainder state (17 steps of
// two bits of the 34-bit pick value, then seeing it finish), the pool read
// state and the commit state, which also writes the pool. fresh allocate,
// release, query and unused codes go through capture, decode and a commit
// state. the ring and pool need no clearing pass after reset or a start_id
// write. the user must write configuration only while no transaction is in
// flight; the block itself does not enforce it.
module id_allocator_with_reuse_delay_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [idalloc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    idalloc_req_if.sink                           i_req,
    idalloc_rsp_if.source                         o_rsp
);

    idalloc_pkg::t_cmd  w_cmd;
    idalloc_pkg::t_stat w_stat;

    idalloc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    idalloc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req.payload),
        .o_rsp      (o_rsp.payload),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

endmodule

// File: tb/idalloc_checker.sv
// scoreboard for the id allocator with reuse delay: mirrors register writes, predicts
// one response per accepted request and compares responses field by field
// depends on idalloc_pkg and the channel interfaces in idalloc_if
module idalloc_checker
    import idalloc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    idalloc_req_if                   i_req,
    idalloc_rsp_if                   i_rsp,
    output int                       o_fail_count,
    output int                       o_pending,
    output logic [COUNT_BITS-1:0]    o_next_fresh,
    output logic [ID_BITS-1:0]       o_start_id
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_LIMIT    = 1 << ID_BITS;
    localparam int PRINT_LIMIT = 40;

    logic [ID_BITS-1:0]    start_id_q;
    logic [SEED_BITS-1:0]  seed_q;
    logic [COUNT_BITS-1:0] fresh_q;
    logic [ID_BITS-1:0]    ring_q [HOLD_DEPTH];
    int                    ring_pos;
    int                    ring_fill;
    logic [ID_BITS-1:0]    pool_q [POOL_DEPTH];
    int                    pool_cnt;
    t_rsp                  due_rsps [$];
    int                    mismatches;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(string what);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // counter back to start_id, ring and pool emptied
    task automatic clear_allocator();
        fresh_q   = COUNT_BITS'(start_id_q);
        ring_pos  = 0;
        ring_fill = 0;
        pool_cnt  = 0;
        for (int i = 0; i < HOLD_DEPTH; i++)
            ring_q[i] = '0;
    endtask

    function automatic t_rsp predict_outcome(input t_req rq);
        t_rsp        rs;
        logic [63:0] mix;
        int          pick;
        rs = '0;
        case (rq.operation)
            OP_ALLOC: begin
                if (pool_cnt != 0) begin
                    mix = 64'(seed_q) + 64'(ring_q[ring_pos]) + 64'(ring_pos) + 64'(fresh_q);
                    pick = int'(mix % 64'(pool_cnt));
                    rs.granted_id = pool_q[pick];
                    pool_q[pick] = pool_q[pool_cnt - 1];
                    pool_cnt--;
                end else if (fresh_q >= ID_LIMIT) begin
                    rs.status = ST_EXHAUSTED;
                end else begin
                    rs.granted_id = fresh_q[ID_BITS-1:0];
                    fresh_q++;
                end
            end
            OP_RELEASE: begin
                if (rq.id_value < start_id_q || rq.id_value >= fresh_q) begin
                    rs.status = ST_RANGE;
                end else begin
                    // a full ring evicts its oldest entry into the pool, or reports overflow when the pool is full
                    if (ring_fill >= HOLD_DEPTH) begin
                        if (pool_cnt < POOL_DEPTH) begin
                            pool_q[pool_cnt] = ring_q[ring_pos];
                            pool_cnt++;
                        end else begin
                            rs.status = ST_OVERFLOW;
                        end
                    end
                    ring_q[ring_pos] = rq.id_value;
                    ring_pos++;
                    if (ring_fill < ring_pos)
                        ring_fill = ring_pos;
                    if (ring_pos >= HOLD_DEPTH)
                        ring_pos = 0;
                end
            end
            OP_QUERY: begin
                rs.was_issued = (rq.id_value >= start_id_q && rq.id_value < fresh_q);
            end
            default: begin
            end
        endcase
        return rs;
    endfunction

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            start_id_q = '0;
            seed_q     = '0;
            clear_allocator();
            due_rsps.delete();
        end else begin
            // response first: it can never belong to a request taken at the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.payload;
                if (due_rsps.size() == 0) begin
                    report_mismatch($sformatf("unexpected response id %0d issued %0d status %0d",
                        got.granted_id, got.was_issued, got.status));
                end else begin
                    want = due_rsps.pop_front();
                    if (got.granted_id !== want.granted_id)
                        report_mismatch($sformatf("granted_id %0d, predicted %0d",
                            got.granted_id, want.granted_id));
                    if (got.was_issued !== want.was_issued)
                        report_mismatch($sformatf("was_issued %0d, predicted %0d",
                            got.was_issued, want.was_issued));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                            got.status, want.status));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_START_ID) begin
                    start_id_q = i_cfg_data[ID_BITS-1:0];
                    clear_allocator();
                end else begin
                    seed_q = i_cfg_data[SEED_BITS-1:0];
                end
            end
            if (i_req.valid && i_req.ready)
                due_rsps = {due_rsps, predict_outcome(i_req.payload)};
        end
        o_pending    <= due_rsps.size();
        o_next_fresh <= fresh_q;
        o_start_id   <= start_id_q;
    end

endmodule

// File: tb/id_allocator_with_reuse_delay_top_test.sv
// stimulus and verdict for the id allocator with reuse delay
// depends on idalloc_pkg, idalloc_if, idalloc_checker and the block's top level
module id_allocator_with_reuse_delay_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import idalloc_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 432;
    localparam int SEGMENTS     = 6;
    localparam int FLOOD_FIRST  = 1000;
    localparam int FLOOD_RELS   = HOLD_DEPTH + POOL_DEPTH + 4;
    localparam int HOLD_OFF     = 400;
    localparam int TAIL_CYCLES  = 40;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     cfg_we  = 1'b0;
    logic                     cfg_idx = 1'b0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int                    fail_count;
    int                    pending;
    logic [COUNT_BITS-1:0] pred_fresh;
    logic [ID_BITS-1:0]    pred_start;
    int                    tx_idle_pct = 12;
    int                    rx_idle_pct = 59;
    logic                  stall_req   = 1'b0;
    int                    cycle_cnt   = 0;

    idalloc_req_if req_ch ();
    idalloc_rsp_if rsp_ch ();

    id_allocator_with_reuse_delay_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    idalloc_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_next_fresh (pred_fresh),
        .o_start_id   (pred_start)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // response side: random back-pressure plus one long hold-off when asked
    initial begin : rx_side
        int  stall_left;
        bit  stall_taken;
        stall_left  = 0;
        stall_taken = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req && !stall_taken) begin
                stall_taken = 1'b1;
                stall_left  = HOLD_OFF;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_req(logic [1:0] op, logic [ID_BITS-1:0] id);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= t_req'{operation: op, id_value: id};
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    // stop offering and wait until every predicted response has been taken
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic set_config(logic [ID_BITS-1:0] first_id, logic [SEED_BITS-1:0] seed);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_START_ID;
        cfg_data <= CFG_DATA_BITS'(first_id);
        @(posedge i_clk);
        cfg_idx  <= CFG_PICK_SEED;
        cfg_data <= CFG_DATA_BITS'(seed);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // mostly in-range releases so the ring fills and the pool gets used
    task automatic random_req();
        int                 roll;
        logic [ID_BITS-1:0] id;
        roll = $urandom_range(99);
        id   = ID_BITS'($urandom);
        if (roll < 33) begin
            send_req(OP_ALLOC, id);
        end else if (roll < 85) begin
            if (pred_fresh > pred_start && $urandom_range(9) != 0)
                id = ID_BITS'(pred_start + $urandom_range(int'(pred_fresh - pred_start) - 1));
            send_req(OP_RELEASE, id);
        end else if (roll < 97) begin
            if ($urandom_range(1)) begin
                case ($urandom_range(3))
                    0: id = ID_BITS'(pred_fresh);
                    1: id = ID_BITS'(pred_fresh - 1'b1);
                    2: id = pred_start;
                    default: id = pred_start - 1'b1;
                endcase
            end
            send_req(OP_QUERY, id);
        end else begin
            send_req(OP_UNUSED, id);
        end
    endtask

    initial begin
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: counter from zero, empty pool
        send_req(OP_QUERY, 10'd0);
        send_req(OP_RELEASE, 10'd0);
        send_req(OP_ALLOC, 10'h3ff);
        send_req(OP_ALLOC, 10'd0);
        send_req(OP_ALLOC, 10'h2aa);
        send_req(OP_QUERY, 10'd2);
        send_req(OP_QUERY, 10'd3);
        send_req(OP_QUERY, 10'h3ff);
        send_req(OP_RELEASE, 10'd1);
        send_req(OP_RELEASE, 10'h3ff);
        send_req(OP_RELEASE, 10'd3);
        send_req(OP_UNUSED, 10'h3ff);
        send_req(OP_ALLOC, 10'h155);
        send_req(OP_QUERY, 10'd0);
        drain();

        // counter near the top: exhaustion and range edges
        set_config(10'd1020, 32'hffff_ffff);
        send_req(OP_QUERY, 10'd1019);
        repeat (4) send_req(OP_ALLOC, 10'd0);
        send_req(OP_ALLOC, 10'd0);
        send_req(OP_QUERY, 10'h3ff);
        send_req(OP_RELEASE, 10'd1019);
        send_req(OP_RELEASE, 10'd1020);
        send_req(OP_RELEASE, 10'h3ff);
        send_req(OP_ALLOC, 10'd0);
        drain();

        // flood the pool past its depth, with one long response hold-off
        set_config(10'(FLOOD_FIRST), 32'hdead_beef);
        stall_req <= 1'b1;
        repeat ((1 << ID_BITS) - FLOOD_FIRST) send_req(OP_ALLOC, 10'd0);
        repeat (FLOOD_RELS)
            send_req(OP_RELEASE, 10'(FLOOD_FIRST + $urandom_range((1 << ID_BITS) - FLOOD_FIRST - 1)));
        repeat (30) send_req(OP_ALLOC, 10'd0);
        repeat (10) send_req(OP_RELEASE, 10'(FLOOD_FIRST + $urandom_range(23)));
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin
                    tx_idle_pct <= 12;
                    rx_idle_pct <= 59;
                end
                1: begin
                    tx_idle_pct <= 59;
                    rx_idle_pct <= 12;
                end
                default: begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
            endcase
            case (seg)
                0: set_config(10'd0, 32'd0);
                1: set_config(10'h3ff, 32'hffff_ffff);
                2: set_config(ID_BITS'($urandom), $urandom);
                3: set_config(10'd900, 32'hffff_ffff);
                4: set_config(ID_BITS'($urandom), $urandom);
                default: set_config(10'd512, 32'd0);
            endcase
            repeat (RANDOM_ITEMS / SEGMENTS) random_req();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
